>>> rtl/cia_pkg.sv
// shared types and constants for the complex integer alu pipeline
// no dependencies
`default_nettype none
package cia_pkg;

    localparam int RESULT_WIDTH = 32;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    localparam logic [RESULT_WIDTH-1:0] RES_MAX = 32'h7fff_ffff;
    localparam logic [RESULT_WIDTH-1:0] RES_MIN = 32'h8000_0000;

    // sign and status flags that ride along with a beat
    typedef struct packed {
        logic neg_re;
        logic neg_im;
        logic dbz;
    } ctl_t;

endpackage
`default_nettype wire

>>> rtl/cia_front.sv
// front stages: operand capture, products, sums and divisor setup
// depends on cia_pkg
`default_nettype none
module cia_front #(
    parameter int W  = 16,
    parameter int NB = 2 * W
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [1:0]    in_op,
    input  wire logic [W-1:0]  in_a,
    input  wire logic [W-1:0]  in_b,
    input  wire logic [W-1:0]  in_c,
    input  wire logic [W-1:0]  in_d,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [NB-1:0]      out_mag_re,
    output logic [NB-1:0]      out_mag_im,
    output logic [NB-1:0]      out_den,
    output cia_pkg::ctl_t      out_ctl
);
    import cia_pkg::*;

    localparam int PW = 2 * W;
    localparam int SW = 2 * W + 2;

    // stage a: operands
    logic                 va_reg;
    op_t                  opa_reg;
    logic signed [W-1:0]  a_reg, b_reg, c_reg, d_reg;
    // stage b: products
    logic                 vb_reg;
    op_t                  opb_reg;
    logic signed [W-1:0]  ab_reg, bb_reg, cb_reg, db_reg;
    logic signed [PW-1:0] ac_reg, bd_reg, ad_reg, bc_reg, cc_reg, dd_reg;
    // stage c: magnitudes and divisor
    logic                 vc_reg;
    logic [NB-1:0]        mre_reg, mim_reg, den_reg;
    ctl_t                 ctl_reg;

    logic en_a, en_b, en_c;
    assign en_c = !vc_reg || out_ready;
    assign en_b = !vb_reg || en_c;
    assign en_a = !va_reg || en_b;
    assign in_ready = en_a;

    logic signed [SW-1:0] re_sum, im_sum, m_sum;
    logic                 is_div, dbz;

    always_comb begin
        is_div = (opb_reg == OP_DIV);
        m_sum  = SW'(cc_reg) + SW'(dd_reg);
        unique case (opb_reg)
            OP_ADD: begin
                re_sum = SW'(ab_reg) + SW'(cb_reg);
                im_sum = SW'(bb_reg) + SW'(db_reg);
            end
            OP_SUB: begin
                re_sum = SW'(ab_reg) - SW'(cb_reg);
                im_sum = SW'(bb_reg) - SW'(db_reg);
            end
            OP_MUL: begin
                re_sum = SW'(ac_reg) - SW'(bd_reg);
                im_sum = SW'(ad_reg) + SW'(bc_reg);
            end
            default: begin
                re_sum = SW'(ac_reg) + SW'(bd_reg);
                im_sum = SW'(bc_reg) - SW'(ad_reg);
            end
        endcase
        dbz = is_div && (m_sum == '0);
    end

    logic signed [SW-1:0] re_abs, im_abs;
    assign re_abs = re_sum[SW-1] ? -re_sum : re_sum;
    assign im_abs = im_sum[SW-1] ? -im_sum : im_sum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end else begin
            if (en_a) va_reg <= in_valid;
            if (en_b) vb_reg <= va_reg;
            if (en_c) vc_reg <= vb_reg;
        end
        if (en_a) begin
            opa_reg <= op_t'(in_op);
            a_reg   <= in_a;
            b_reg   <= in_b;
            c_reg   <= in_c;
            d_reg   <= in_d;
        end
        if (en_b) begin
            opb_reg <= opa_reg;
            ab_reg  <= a_reg;
            bb_reg  <= b_reg;
            cb_reg  <= c_reg;
            db_reg  <= d_reg;
            ac_reg  <= a_reg * c_reg;
            bd_reg  <= b_reg * d_reg;
            ad_reg  <= a_reg * d_reg;
            bc_reg  <= b_reg * c_reg;
            cc_reg  <= c_reg * c_reg;
            dd_reg  <= d_reg * d_reg;
        end
        if (en_c) begin
            // non-divide beats divide by one so they share the divider path
            if (dbz) begin
                mre_reg <= '0;
                mim_reg <= '0;
                den_reg <= NB'(1);
            end else begin
                mre_reg <= re_abs[NB-1:0];
                mim_reg <= im_abs[NB-1:0];
                den_reg <= is_div ? m_sum[NB-1:0] : NB'(1);
            end
            ctl_reg.neg_re <= re_sum[SW-1] && !dbz;
            ctl_reg.neg_im <= im_sum[SW-1] && !dbz;
            ctl_reg.dbz    <= dbz;
        end
    end

    assign out_valid  = vc_reg;
    assign out_mag_re = mre_reg;
    assign out_mag_im = mim_reg;
    assign out_den    = den_reg;
    assign out_ctl    = ctl_reg;

endmodule
`default_nettype wire

>>> rtl/cia_div_stage.sv
// one quotient bit of the pipelined restoring divider, real and imag lanes
// depends on cia_pkg
`default_nettype none
module cia_div_stage #(
    parameter int NB = 32
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [NB-1:0] in_rem_re,
    input  wire logic [NB-1:0] in_quo_re,
    input  wire logic [NB-1:0] in_rem_im,
    input  wire logic [NB-1:0] in_quo_im,
    input  wire logic [NB-1:0] in_den,
    input  wire cia_pkg::ctl_t in_ctl,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [NB-1:0]      out_rem_re,
    output logic [NB-1:0]      out_quo_re,
    output logic [NB-1:0]      out_rem_im,
    output logic [NB-1:0]      out_quo_im,
    output logic [NB-1:0]      out_den,
    output cia_pkg::ctl_t      out_ctl
);
    import cia_pkg::*;

    logic          v_reg;
    logic [NB-1:0] rre_reg, qre_reg, rim_reg, qim_reg, den_reg;
    ctl_t          ctl_reg;

    logic en;
    assign en = !v_reg || out_ready;
    assign in_ready = en;

    logic [NB:0] sh_re, sh_im, dext;
    logic        ge_re, ge_im;
    logic [NB:0] nr_re, nr_im;

    always_comb begin
        dext  = {1'b0, in_den};
        sh_re = {in_rem_re, in_quo_re[NB-1]};
        sh_im = {in_rem_im, in_quo_im[NB-1]};
        ge_re = sh_re >= dext;
        ge_im = sh_im >= dext;
        nr_re = ge_re ? sh_re - dext : sh_re;
        nr_im = ge_im ? sh_im - dext : sh_im;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= in_valid;
        end
        if (en) begin
            rre_reg <= nr_re[NB-1:0];
            rim_reg <= nr_im[NB-1:0];
            qre_reg <= {in_quo_re[NB-2:0], ge_re};
            qim_reg <= {in_quo_im[NB-2:0], ge_im};
            den_reg <= in_den;
            ctl_reg <= in_ctl;
        end
    end

    assign out_valid  = v_reg;
    assign out_rem_re = rre_reg;
    assign out_quo_re = qre_reg;
    assign out_rem_im = rim_reg;
    assign out_quo_im = qim_reg;
    assign out_den    = den_reg;
    assign out_ctl    = ctl_reg;

endmodule
`default_nettype wire

>>> rtl/complex_integer_alu_core.sv
// complex integer alu: add, subtract, multiply, divide on gaussian integers
// operand, product and sum stages, one divider stage per quotient bit, then the
// saturating output register
// throughput one beat per cycle when m_ready is high; each beat passes the bit-per-stage divider
// synchronous active-low reset clears all valid bits; data registers are not reset
// depends on cia_pkg, cia_front, cia_div_stage
`default_nettype none
module complex_integer_alu_core #(
    parameter int OPERAND_WIDTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [1:0]               s_operation,
    input  wire logic [OPERAND_WIDTH-1:0] s_lhs_real,
    input  wire logic [OPERAND_WIDTH-1:0] s_lhs_imag,
    input  wire logic [OPERAND_WIDTH-1:0] s_rhs_real,
    input  wire logic [OPERAND_WIDTH-1:0] s_rhs_imag,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [cia_pkg::RESULT_WIDTH-1:0] m_result_real,
    output logic [cia_pkg::RESULT_WIDTH-1:0] m_result_imag,
    output logic                          m_divide_by_zero
);
    import cia_pkg::*;

    localparam int NB = 2 * OPERAND_WIDTH;
    localparam int XW = ((NB > RESULT_WIDTH) ? NB : RESULT_WIDTH) + 1;
    localparam logic [XW-1:0] LIM_POS = XW'(RES_MAX);
    localparam logic [XW-1:0] LIM_NEG = XW'(RES_MIN);

    logic          v_w   [0:NB];
    logic          rdy_w [0:NB];
    logic [NB-1:0] rre_w [0:NB];
    logic [NB-1:0] qre_w [0:NB];
    logic [NB-1:0] rim_w [0:NB];
    logic [NB-1:0] qim_w [0:NB];
    logic [NB-1:0] den_w [0:NB];
    ctl_t          ctl_w [0:NB];

    assign rre_w[0] = '0;
    assign rim_w[0] = '0;

    cia_front #(.W(OPERAND_WIDTH), .NB(NB)) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_op      (s_operation),
        .in_a       (s_lhs_real),
        .in_b       (s_lhs_imag),
        .in_c       (s_rhs_real),
        .in_d       (s_rhs_imag),
        .out_valid  (v_w[0]),
        .out_ready  (rdy_w[0]),
        .out_mag_re (qre_w[0]),
        .out_mag_im (qim_w[0]),
        .out_den    (den_w[0]),
        .out_ctl    (ctl_w[0])
    );

    for (genvar k = 0; k < NB; k++) begin : g_div
        cia_div_stage #(.NB(NB)) u_stage (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .in_valid   (v_w[k]),
            .in_ready   (rdy_w[k]),
            .in_rem_re  (rre_w[k]),
            .in_quo_re  (qre_w[k]),
            .in_rem_im  (rim_w[k]),
            .in_quo_im  (qim_w[k]),
            .in_den     (den_w[k]),
            .in_ctl     (ctl_w[k]),
            .out_valid  (v_w[k+1]),
            .out_ready  (rdy_w[k+1]),
            .out_rem_re (rre_w[k+1]),
            .out_quo_re (qre_w[k+1]),
            .out_rem_im (rim_w[k+1]),
            .out_quo_im (qim_w[k+1]),
            .out_den    (den_w[k+1]),
            .out_ctl    (ctl_w[k+1])
        );
    end

    function automatic logic [RESULT_WIDTH-1:0] sat(input logic neg, input logic [NB-1:0] mag);
        logic [XW-1:0] ext;
        logic [XW-1:0] nval;
        ext  = XW'(mag);
        nval = -ext;
        if (neg) begin
            return (ext >= LIM_NEG) ? RES_MIN : nval[RESULT_WIDTH-1:0];
        end
        return (ext > LIM_POS) ? RES_MAX : ext[RESULT_WIDTH-1:0];
    endfunction

    logic                    mv_reg;
    logic [RESULT_WIDTH-1:0] re_reg, im_reg;
    logic                    dbz_reg;
    logic                    en_out;

    assign en_out    = !mv_reg || m_ready;
    assign rdy_w[NB] = en_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg <= 1'b0;
        end else if (en_out) begin
            mv_reg <= v_w[NB];
        end
        if (en_out) begin
            re_reg  <= sat(ctl_w[NB].neg_re, qre_w[NB]);
            im_reg  <= sat(ctl_w[NB].neg_im, qim_w[NB]);
            dbz_reg <= ctl_w[NB].dbz;
        end
    end

    assign m_valid          = mv_reg;
    assign m_result_real    = re_reg;
    assign m_result_imag    = im_reg;
    assign m_divide_by_zero = dbz_reg;

    a_dbz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_divide_by_zero) |-> (m_result_real == '0 && m_result_imag == '0))
        else $error("divide by zero beat carries a nonzero result");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_result_real)
            && $stable(m_result_imag) && $stable(m_divide_by_zero)))
        else $error("stalled output beat changed");

endmodule
`default_nettype wire

>>> tb/sv/tb_complex_integer_alu_core.sv
// testbench for complex_integer_alu_core: gaussian integer add, sub, mul, div
// random bursts and receiver stalls, in-order checking against a built-in predictor
// depends on cia_pkg and the rtl of complex_integer_alu_core
`timescale 1ns / 1ps
module tb_complex_integer_alu_core;
    import cia_pkg::*;

    localparam int W = 16;
    localparam int N_RANDOM = 2000;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        op_t          op;
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic [W-1:0] c;
        logic [W-1:0] d;
    } operand_beat_t;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic        dbz;
    } alu_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_operation = '0;
    logic [W-1:0] s_lhs_real = '0, s_lhs_imag = '0, s_rhs_real = '0, s_rhs_imag = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [31:0] m_result_real, m_result_imag;
    logic m_divide_by_zero;

    operand_beat_t pending_beats[$];
    alu_result_t   expected_results[$];
    int  error_count = 0;
    bit  stimulus_done = 1'b0;
    bit  in_taken = 1'b0;
    longint cycle_count = 0;

    complex_integer_alu_core #(.OPERAND_WIDTH(W)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_lhs_real(s_lhs_real), .s_lhs_imag(s_lhs_imag),
        .s_rhs_real(s_rhs_real), .s_rhs_imag(s_rhs_imag),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_real(m_result_real), .m_result_imag(m_result_imag),
        .m_divide_by_zero(m_divide_by_zero)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7fff_ffff;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // exact 64-bit math; signed division truncates toward zero
    function automatic alu_result_t gaussian_result(operand_beat_t t);
        alu_result_t r;
        longint a, b, c, d, m;
        a = longint'($signed(t.a));
        b = longint'($signed(t.b));
        c = longint'($signed(t.c));
        d = longint'($signed(t.d));
        r.dbz = 1'b0;
        case (t.op)
            OP_ADD: begin r.re = clamp32(a + c); r.im = clamp32(b + d); end
            OP_SUB: begin r.re = clamp32(a - c); r.im = clamp32(b - d); end
            OP_MUL: begin r.re = clamp32(a*c - b*d); r.im = clamp32(a*d + b*c); end
            default: begin
                m = c*c + d*d;
                if (m == 0) begin
                    r.re = '0; r.im = '0; r.dbz = 1'b1;
                end else begin
                    r.re = clamp32((a*c + b*d) / m);
                    r.im = clamp32((b*c - a*d) / m);
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [W-1:0] random_operand();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return '0;
            3: return W'($signed($urandom_range(0, 6)) - 3);
            default: return W'($urandom);
        endcase
    endfunction

    task automatic add_beat(op_t op, logic [W-1:0] a, logic [W-1:0] b,
                            logic [W-1:0] c, logic [W-1:0] d);
        operand_beat_t t;
        t.op = op; t.a = a; t.b = b; t.c = c; t.d = d;
        pending_beats.push_back(t);
    endtask

    initial begin
        operand_beat_t t;
        int k;
        add_beat(OP_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        add_beat(OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        add_beat(OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        add_beat(OP_SUB, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        add_beat(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        add_beat(OP_MUL, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        add_beat(OP_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        add_beat(OP_MUL, 16'h0003, 16'hfffe, 16'h0005, 16'h0007);
        add_beat(OP_DIV, 16'h1234, 16'h8000, 16'h0000, 16'h0000);
        add_beat(OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        add_beat(OP_DIV, 16'h0007, 16'hfff9, 16'h0002, 16'h0000);
        add_beat(OP_DIV, 16'hfff9, 16'h0007, 16'h0000, 16'hfffe);
        add_beat(OP_DIV, 16'h8000, 16'h8000, 16'h0001, 16'h0000);
        add_beat(OP_DIV, 16'h8000, 16'h8000, 16'hffff, 16'hffff);
        add_beat(OP_DIV, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
        add_beat(OP_DIV, 16'h0001, 16'h0001, 16'h7fff, 16'h8000);
        add_beat(OP_DIV, 16'h0005, 16'h0003, 16'h0003, 16'h0004);
        for (k = 0; k < N_RANDOM; k++) begin
            t.op = op_t'($urandom_range(0, 3));
            t.a = random_operand(); t.b = random_operand();
            t.c = random_operand(); t.d = random_operand();
            // keep zero divisors occasional
            if (t.op == OP_DIV && $urandom_range(0, 19) == 0) begin
                t.c = '0; t.d = '0;
            end
            pending_beats.push_back(t);
        end
        stimulus_done = 1'b1;
    end

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    // input beat taken at the last rising edge
    always @(posedge aclk) begin
        in_taken <= s_valid && s_ready;
    end

    // driver: bursts of beats separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_valid && !in_taken) begin
                // hold the beat until it is taken
            end else if (burst_left == 0 && gap_left > 0) begin
                s_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_beats.size() > 0) begin
                operand_beat_t t;
                t = pending_beats.pop_front();
                s_valid <= 1'b1;
                s_operation <= t.op;
                s_lhs_real <= t.a; s_lhs_imag <= t.b;
                s_rhs_real <= t.c; s_rhs_imag <= t.d;
                expected_results.push_back(gaussian_result(t));
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern: alternating phases of full rate and random stalls
    always @(negedge aclk) begin
        if (aresetn) begin
            if ((cycle_count / 500) % 3 == 0) m_ready <= 1'b1;
            else if ((cycle_count / 500) % 3 == 1) m_ready <= ($urandom_range(0, 3) != 0);
            else m_ready <= ($urandom_range(0, 4) == 0);
        end
    end

    // monitor
    always @(posedge aclk) begin
        alu_result_t e;
        cycle_count <= cycle_count + 1;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with no expectation: re %h im %h", m_result_real,
                       m_result_imag);
                error_count++;
            end else begin
                e = expected_results.pop_front();
                if (m_result_real !== e.re) begin
                    $error("result_real expected %h actual %h", e.re, m_result_real);
                    error_count++;
                end
                if (m_result_imag !== e.im) begin
                    $error("result_imag expected %h actual %h", e.im, m_result_imag);
                    error_count++;
                end
                if (m_divide_by_zero !== e.dbz) begin
                    $error("divide_by_zero expected %b actual %b", e.dbz, m_divide_by_zero);
                    error_count++;
                end
            end
        end
    end

    initial begin
        wait (aresetn && stimulus_done);
        while (pending_beats.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout waiting for results");
        $display("status: fail");
        $finish;
    end
endmodule
